// File: hdl/hac_pkg.sv
// Package for the high-resolution artifact colour decoder.
// Holds the result type, colour codes and the per-pixel colour functions.
// Depends on nothing.
`timescale 1ns / 1ps

package hac_pkg;

    localparam int PIX_PER_BYTE = 7;
    localparam int QUEUE_DEPTH  = 3;
    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] COLOUR_BLACK = 2'd0;
    localparam logic [1:0] COLOUR_ONE   = 2'd1;
    localparam logic [1:0] COLOUR_TWO   = 2'd2;
    localparam logic [1:0] COLOUR_WHITE = 2'd3;

    typedef logic [PIX_PER_BYTE-1:0] byte_t;

    typedef struct packed {
        logic [PIX_PER_BYTE-1:0][1:0] colour;
        logic                         line_done;
    } result_t;

    // Colour of one pixel from its own bit, its neighbours and its column parity.
    function automatic logic [1:0] pixel_colour(input logic l, input logic m,
                                                input logic r, input logic even);
        logic [1:0] c;
        if (m)
        begin
            if (l | r)
            begin
                c = COLOUR_WHITE;
            end
            else
            begin
                c = even ? COLOUR_TWO : COLOUR_ONE;
            end
        end
        else if (l & r)
        begin
            c = even ? COLOUR_ONE : COLOUR_TWO;
        end
        else
        begin
            c = COLOUR_BLACK;
        end
        return c;
    endfunction

    // Colours a whole byte; the nine-bit window is left pixel, byte, right pixel.
    function automatic result_t emit_byte(input byte_t pix, input logic lft,
                                          input logic rgt, input logic odd,
                                          input logic done);
        logic [PIX_PER_BYTE+1:0] win;
        logic [$clog2(PIX_PER_BYTE)-1:0] p;
        result_t res;
        win = {rgt, pix, lft};
        for (int i = 0; i < PIX_PER_BYTE; i++)
        begin
            p = i[$clog2(PIX_PER_BYTE)-1:0];
            res.colour[i] = pixel_colour(win[i], win[i+1], win[i+2], ~(odd ^ p[0]));
        end
        res.line_done = done;
        return res;
    endfunction

endpackage

// File: hdl/hires_artifact_colour.sv
// Top level of the high-resolution artifact colour decoder.
// Depends on hac_pkg for the result type and the colour functions.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                  Payload
//  byte      in         byte_valid / byte_stall    pixel_bits[6:0], line_end
//  colour    out        colour_valid / colour_stall colour_0..colour_6[1:0], line_done
//
// A byte is coloured when its right neighbour is accepted (a line's last byte when it is
// accepted) and its results go straight into a three-entry result queue, so one byte can
// be taken in every cycle while the queue holds at most one result. A byte normally gives
// one result, for the byte before it; the last byte of a line of two or more bytes gives
// two, and the input is then held off while the queue drains. A one-byte line gives one.
// Reset (rst_n low, asynchronous) empties the queue and returns to line start. The input
// is stalled while the queue holds more than one result; an output stall holds the head.

module hires_artifact_colour (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [6:0] pixel_bits,
    input  logic       line_end,
    output logic       colour_valid,
    input  logic       colour_stall,
    output logic [1:0] colour_0,
    output logic [1:0] colour_1,
    output logic [1:0] colour_2,
    output logic [1:0] colour_3,
    output logic [1:0] colour_4,
    output logic [1:0] colour_5,
    output logic [1:0] colour_6,
    output logic       line_done
);

    localparam int DEPTH = hac_pkg::QUEUE_DEPTH;
    localparam int CW    = hac_pkg::COUNT_W;

    // Line state: the byte waiting for its right neighbour and what lies to its left.
    hac_pkg::byte_t held_byte_reg, held_byte_next;
    logic           held_valid_reg, held_valid_next;
    logic           left_pixel_reg, left_pixel_next;
    logic           held_odd_reg, held_odd_next;

    // Result queue; entry 0 is the head that drives the output ports.
    hac_pkg::result_t queue_reg [DEPTH];
    hac_pkg::result_t queue_next [DEPTH];
    logic [CW-1:0]    count_reg, count_next;

    logic             in_accept;
    logic             out_pop;
    logic             lft_new;
    logic             odd_new;
    hac_pkg::result_t res_held;
    hac_pkg::result_t res_last;
    hac_pkg::result_t res_first;
    logic [CW-1:0]    base;
    logic [CW-1:0]    n_push;

    assign byte_stall   = (count_reg > CW'(1));
    assign in_accept    = byte_valid && !byte_stall;
    assign colour_valid = (count_reg != '0);
    assign out_pop      = colour_valid && !colour_stall;

    // Neighbour and parity for the new byte, should it close the line.
    assign lft_new = held_valid_reg ? held_byte_reg[hac_pkg::PIX_PER_BYTE-1] : 1'b0;
    assign odd_new = held_valid_reg ? ~held_odd_reg : 1'b0;

    always_comb
    begin
        res_held  = hac_pkg::emit_byte(held_byte_reg, left_pixel_reg, pixel_bits[0],
                                       held_odd_reg, 1'b0);
        res_last  = hac_pkg::emit_byte(pixel_bits, lft_new, 1'b0, odd_new, 1'b1);
        res_first = held_valid_reg ? res_held : res_last;
        n_push    = CW'(held_valid_reg) + CW'(line_end);
        base      = count_reg - CW'(out_pop);

        for (int i = 0; i < DEPTH; i++)
        begin
            if (out_pop && (i < DEPTH - 1))
            begin
                queue_next[i] = queue_reg[(i + 1) % DEPTH];
            end
            else
            begin
                queue_next[i] = queue_reg[i];
            end
            if (in_accept && (n_push != '0) && (CW'(i) == base))
            begin
                queue_next[i] = res_first;
            end
            if (in_accept && (n_push == CW'(2)) && (CW'(i) == base + CW'(1)))
            begin
                queue_next[i] = res_last;
            end
        end

        count_next = in_accept ? base + n_push : base;

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        left_pixel_next = left_pixel_reg;
        held_odd_next   = held_odd_reg;
        if (in_accept)
        begin
            if (line_end)
            begin
                // The line is finished: everything goes back to line start.
                held_byte_next  = '0;
                held_valid_next = 1'b0;
                left_pixel_next = 1'b0;
                held_odd_next   = 1'b0;
            end
            else
            begin
                held_byte_next  = pixel_bits;
                held_valid_next = 1'b1;
                left_pixel_next = lft_new;
                held_odd_next   = odd_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            left_pixel_reg <= 1'b0;
            held_odd_reg   <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            left_pixel_reg <= left_pixel_next;
            held_odd_reg   <= held_odd_next;
            count_reg      <= count_next;
        end
    end

    // The queue entries are payload and need no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

    assign colour_0  = queue_reg[0].colour[0];
    assign colour_1  = queue_reg[0].colour[1];
    assign colour_2  = queue_reg[0].colour[2];
    assign colour_3  = queue_reg[0].colour[3];
    assign colour_4  = queue_reg[0].colour[4];
    assign colour_5  = queue_reg[0].colour[5];
    assign colour_6  = queue_reg[0].colour[6];
    assign line_done = queue_reg[0].line_done;

`ifndef SYNTHESIS
    // The queue can never overfill.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overfilled");

    // A line end always returns the block to line start.
    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && line_end |=> !held_valid_reg && !held_odd_reg && !left_pixel_reg)
        else $error("line state not cleared after line end");

    // A byte that does not end its line is always held for the next one.
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !line_end |=> held_valid_reg)
        else $error("byte not held after request");

    // Two results from one request leave at least two entries queued.
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && line_end && held_valid_reg |=> count_reg >= CW'(2))
        else $error("line end results lost");
`endif

endmodule
